@@ design/mcu_timer_counter_pair_top_assert.svh @@
// Assertion macros for the timer/counter pair checker.
`ifndef MCU_TIMER_COUNTER_PAIR_TOP_ASSERT_SVH
`define MCU_TIMER_COUNTER_PAIR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTCP_ASSERT_IMPLY(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTCP_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ design/mtcp_pkg.sv @@
// Package with types, codes, constants and the count step for the timer/counter pair.
package mtcp_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_EXT_CLK  = 3'd1;
    localparam logic [2:0] OP_T0_PULSE = 3'd2;
    localparam logic [2:0] OP_T1_PULSE = 3'd3;
    localparam logic [2:0] OP_T2_PULSE = 3'd4;
    localparam logic [2:0] OP_ENTRY    = 3'd5;
    localparam logic [2:0] OP_EXIT     = 3'd6;
    localparam logic [2:0] OP_WRITE    = 3'd7;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_RUN      = 2'd1;
    localparam logic [1:0] REG_INT_EN   = 2'd2;
    localparam logic [1:0] REG_INT_PRIO = 2'd3;

    localparam logic [1:0] SEL_TL0 = 2'd0;
    localparam logic [1:0] SEL_TH0 = 2'd1;
    localparam logic [1:0] SEL_TL1 = 2'd2;
    localparam logic [1:0] SEL_TH1 = 2'd3;

    localparam logic [1:0] VEC_OTHER = 2'd3;

    localparam logic [1:0] MODE_13BIT  = 2'd0;
    localparam logic [1:0] MODE_16BIT  = 2'd1;
    localparam logic [1:0] MODE_RELOAD = 2'd2;
    localparam logic [1:0] MODE_SPLIT  = 2'd3;

    localparam int GATE_POS  = 3;
    localparam int CT_POS    = 2;
    localparam int IE_EA_POS = 7;

    localparam logic [4:0] LOW5_MAX = 5'd31;
    localparam logic [7:0] BYTE_MAX = 8'd255;

    typedef struct packed {
        logic [2:0] op;
        logic       ext_clk_enable;
        logic       gate0_level;
        logic       gate1_level;
        logic [1:0] nest_level;
        logic [1:0] entered_vector;
        logic       tf2_set;
        logic [1:0] reg_select;
        logic [7:0] write_data;
    } in_t;

    typedef struct packed {
        logic [7:0] low0;
        logic [7:0] high0;
        logic [7:0] low1;
        logic [7:0] high1;
        logic [2:0] overflow_flags;
        logic [2:0] irq_request;
        logic [2:0] irq_high;
    } out_t;

    typedef struct packed {
        logic [7:0] mode_bits;
        logic [1:0] run_bits;
        logic [7:0] int_enable;
        logic [7:0] int_priority;
    } cfg_t;

    typedef struct packed {
        logic [7:0] count0_low;
        logic [7:0] count0_high;
        logic [7:0] count1_low;
        logic [7:0] count1_high;
        logic [2:0] overflow_state;
        logic [2:0] clear_pending;
        logic       ext_clock_mode;
    } state_t;

    typedef struct packed {
        logic [7:0] lo;
        logic [7:0] hi;
        logic       ovf;
    } adv_t;

    // One count step of a timer in the given mode.
    function automatic adv_t advance(input logic [1:0] mode, input logic [7:0] lo,
                                     input logic [7:0] hi);
        adv_t r;
        r.lo  = lo;
        r.hi  = hi;
        r.ovf = 1'b0;
        case (mode)
            MODE_13BIT: begin
                if (lo[4:0] == LOW5_MAX) begin
                    r.ovf = (hi == BYTE_MAX);
                    r.hi  = hi + 8'd1;
                end
                r.lo = {lo[7:5], lo[4:0] + 5'd1};
            end
            MODE_16BIT: begin
                if (lo == BYTE_MAX) begin
                    r.ovf = (hi == BYTE_MAX);
                    r.hi  = hi + 8'd1;
                end
                r.lo = lo + 8'd1;
            end
            MODE_RELOAD: begin
                if (lo == BYTE_MAX) begin
                    r.lo  = hi;
                    r.ovf = 1'b1;
                end else begin
                    r.lo = lo + 8'd1;
                end
            end
            default: begin
                r.ovf = (lo == BYTE_MAX);
                r.lo  = lo + 8'd1;
            end
        endcase
        return r;
    endfunction

endpackage

@@ design/mtcp_update.sv @@
// Next-state and result logic for one transaction of the timer/counter pair.
module mtcp_update (
    input  mtcp_pkg::cfg_t   cfg,
    input  mtcp_pkg::state_t st,
    input  mtcp_pkg::in_t    item,
    output mtcp_pkg::state_t st_next,
    output mtcp_pkg::out_t   result
);

    logic [3:0]        m0;
    logic [3:0]        m1;
    logic              ev_tick;
    logic              ev_pin0;
    logic              ev_pin1;
    logic              split;
    logic              en0;
    logic              en1;
    logic              split_hi_en;
    mtcp_pkg::adv_t    adv0;
    mtcp_pkg::adv_t    adv1;
    mtcp_pkg::state_t  nxt;
    logic [2:0]        ovf;
    logic [2:0]        req;
    logic [2:0]        high;

    assign m0 = cfg.mode_bits[3:0];
    assign m1 = cfg.mode_bits[7:4];

    assign ev_tick = ((item.op == mtcp_pkg::OP_TICK) && !st.ext_clock_mode) ||
                     ((item.op == mtcp_pkg::OP_EXT_CLK) && item.ext_clk_enable);
    assign ev_pin0 = (item.op == mtcp_pkg::OP_T0_PULSE);
    assign ev_pin1 = (item.op == mtcp_pkg::OP_T1_PULSE);
    assign split   = (m0[1:0] == mtcp_pkg::MODE_SPLIT);

    assign en0 = cfg.run_bits[0] && (m0[mtcp_pkg::CT_POS] ? ev_pin0 : ev_tick) &&
                 (!m0[mtcp_pkg::GATE_POS] || item.gate0_level);
    assign en1 = cfg.run_bits[1] && !split && (m1[mtcp_pkg::CT_POS] ? ev_pin1 : ev_tick) &&
                 (!m1[mtcp_pkg::GATE_POS] || item.gate1_level) &&
                 (m1[1:0] != mtcp_pkg::MODE_SPLIT);
    assign split_hi_en = cfg.run_bits[1] && split && ev_tick;

    assign adv0 = mtcp_pkg::advance(m0[1:0], st.count0_low, st.count0_high);
    assign adv1 = mtcp_pkg::advance(m1[1:0], st.count1_low, st.count1_high);

    always_comb begin
        nxt  = st;
        ovf  = st.overflow_state | {item.tf2_set, 2'b00};
        req  = 3'b000;
        high = 3'b000;
        if (en0) begin
            nxt.count0_low  = adv0.lo;
            nxt.count0_high = adv0.hi;
            if (adv0.ovf) begin
                ovf[0] = 1'b1;
            end
        end
        if (en1) begin
            nxt.count1_low  = adv1.lo;
            nxt.count1_high = adv1.hi;
            if (adv1.ovf) begin
                ovf[1] = 1'b1;
            end
        end
        if (split_hi_en) begin
            if (nxt.count0_high == mtcp_pkg::BYTE_MAX) begin
                ovf[1] = 1'b1;
            end
            nxt.count0_high = nxt.count0_high + 8'd1;
        end
        unique case (item.op) inside
            mtcp_pkg::OP_TICK: begin
                if (cfg.int_enable[mtcp_pkg::IE_EA_POS]) begin
                    for (int i = 0; i < 3; i++) begin
                        if (ovf[i] && cfg.int_enable[2*i+1]) begin
                            if (cfg.int_priority[2*i+1]) begin
                                if (item.nest_level < 2'd2) begin
                                    req[i]  = 1'b1;
                                    high[i] = 1'b1;
                                end
                            end else if (item.nest_level == 2'd0) begin
                                req[i] = 1'b1;
                            end
                        end
                    end
                end
            end
            mtcp_pkg::OP_EXT_CLK: begin
                nxt.ext_clock_mode = item.ext_clk_enable;
            end
            mtcp_pkg::OP_T0_PULSE, mtcp_pkg::OP_T1_PULSE, mtcp_pkg::OP_T2_PULSE: begin
            end
            mtcp_pkg::OP_ENTRY: begin
                if (item.entered_vector != mtcp_pkg::VEC_OTHER) begin
                    nxt.clear_pending[item.entered_vector] = 1'b1;
                end
            end
            mtcp_pkg::OP_EXIT: begin
                ovf               = ovf & ~st.clear_pending;
                nxt.clear_pending = 3'b000;
            end
            default: begin
                case (item.reg_select)
                    mtcp_pkg::SEL_TL0: nxt.count0_low  = item.write_data;
                    mtcp_pkg::SEL_TH0: nxt.count0_high = item.write_data;
                    mtcp_pkg::SEL_TL1: nxt.count1_low  = item.write_data;
                    default:           nxt.count1_high = item.write_data;
                endcase
            end
        endcase
        nxt.overflow_state = ovf;
    end

    assign st_next = nxt;

    assign result.low0           = nxt.count0_low;
    assign result.high0          = nxt.count0_high;
    assign result.low1           = nxt.count1_low;
    assign result.high1          = nxt.count1_high;
    assign result.overflow_flags = nxt.overflow_state;
    assign result.irq_request    = req;
    assign result.irq_high       = high;

endmodule

@@ design/mcu_timer_counter_pair_top.sv @@
// Top level of the timer/counter pair with interrupt request logic.
// An accepted transaction is held in the input register, and its result is then registered in
// the result register that drives m_data.
// Throughput: one transaction per cycle while results are taken; the timer state register
// updates together with the result register, from the transaction in the input register.
// Input stalls only while both registers are full and the result is not taken.
// Reset is synchronous and active low; it clears counts, flags and configuration.
module mcu_timer_counter_pair_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mtcp_pkg::in_t                       s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mtcp_pkg::out_t                      m_data,
    input  logic                                cfg_wen,
    input  logic [mtcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mtcp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    mtcp_pkg::cfg_t    cfg_reg;
    mtcp_pkg::state_t  state_reg;
    mtcp_pkg::state_t  state_next;
    logic              in_valid_reg;
    mtcp_pkg::in_t     in_data_reg;
    logic              out_valid_reg;
    mtcp_pkg::out_t    out_data_reg;
    mtcp_pkg::out_t    out_data_next;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    mtcp_update u_update (
        .cfg     (cfg_reg),
        .st      (state_reg),
        .item    (in_data_reg),
        .st_next (state_next),
        .result  (out_data_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                mtcp_pkg::REG_MODE:     cfg_reg.mode_bits    <= cfg_wdata;
                mtcp_pkg::REG_RUN:      cfg_reg.run_bits     <= cfg_wdata[1:0];
                mtcp_pkg::REG_INT_EN:   cfg_reg.int_enable   <= cfg_wdata;
                mtcp_pkg::REG_INT_PRIO: cfg_reg.int_priority <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

@@ design/mtcp_checker.sv @@
// Port-level checker for the timer/counter pair and its bind to the top level.
`include "mcu_timer_counter_pair_top_assert.svh"

module mtcp_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_ready,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  mtcp_pkg::out_t                      m_data
);

    // A high-priority mark never appears without its request.
    `MTCP_ASSERT_IMPLY(a_high_has_req, aclk, aresetn, m_valid,
        (m_data.irq_high & ~m_data.irq_request) == 3'b000, "priority mark without request")

    // A request is raised only from an overflow flag that is set.
    `MTCP_ASSERT_IMPLY(a_req_has_flag, aclk, aresetn, m_valid,
        (m_data.irq_request & ~m_data.overflow_flags) == 3'b000, "request without overflow flag")

    // The input side stalls only while a result is waiting and not taken.
    `MTCP_ASSERT_IMPLY(a_stall_cause, aclk, aresetn, !s_ready,
        m_valid && !m_ready, "input stalled with free result register")

    // A result that is not taken stays put.
    `MTCP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data), "stalled result changed")

endmodule

bind mcu_timer_counter_pair_top mtcp_checker u_checker (.*);

@@ sim/tb_mcu_timer_counter_pair_top.sv @@
// Testbench for the timer/counter pair: directed and random transactions checked by a predictor.
`timescale 1ns / 1ps

module tb_mcu_timer_counter_pair_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 9;
    localparam int PHASE_ITEMS = 150;
    localparam int LONG_HOLD   = 150;
    localparam int HOLD_AFTER  = 300;

    class timer_pair_scoreboard;
        logic [7:0]     tmod;
        logic [1:0]     tr;
        logic [7:0]     ie;
        logic [7:0]     ip;
        logic [7:0]     tl0, th0, tl1, th1;
        logic [2:0]     tf;
        logic [2:0]     pend;
        logic           ext_mode;
        mtcp_pkg::out_t awaited[$];
        int             failures;

        function new();
            tmod = '0;
            tr = '0;
            ie = '0;
            ip = '0;
            tl0 = '0;
            th0 = '0;
            tl1 = '0;
            th1 = '0;
            tf = '0;
            pend = '0;
            ext_mode = 1'b0;
            failures = 0;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [7:0] d);
            case (idx)
                mtcp_pkg::REG_MODE:     tmod = d;
                mtcp_pkg::REG_RUN:      tr = d[1:0];
                mtcp_pkg::REG_INT_EN:   ie = d;
                mtcp_pkg::REG_INT_PRIO: ip = d;
            endcase
        endfunction

        // Steps one timer by one count and returns its overflow.
        function logic bump(input logic [1:0] mode, inout logic [7:0] lo, inout logic [7:0] hi);
            logic carry;
            carry = 1'b0;
            case (mode)
                mtcp_pkg::MODE_13BIT: begin
                    if (lo[4:0] == mtcp_pkg::LOW5_MAX) begin
                        carry = (hi == mtcp_pkg::BYTE_MAX);
                        hi = hi + 8'd1;
                    end
                    lo[4:0] = lo[4:0] + 5'd1;
                end
                mtcp_pkg::MODE_16BIT: begin
                    if (lo == mtcp_pkg::BYTE_MAX) begin
                        carry = (hi == mtcp_pkg::BYTE_MAX);
                        hi = hi + 8'd1;
                    end
                    lo = lo + 8'd1;
                end
                mtcp_pkg::MODE_RELOAD: begin
                    carry = (lo == mtcp_pkg::BYTE_MAX);
                    lo = carry ? hi : lo + 8'd1;
                end
                mtcp_pkg::MODE_SPLIT: begin
                    carry = (lo == mtcp_pkg::BYTE_MAX);
                    lo = lo + 8'd1;
                end
            endcase
            return carry;
        endfunction

        function void count(input logic [2:0] src, input logic g0, input logic g1);
            logic [3:0] m0, m1;
            logic       tick;
            m0 = tmod[3:0];
            m1 = tmod[7:4];
            tick = (src == mtcp_pkg::OP_TICK);
            if (tr[0] && (m0[mtcp_pkg::CT_POS] ? src == mtcp_pkg::OP_T0_PULSE : tick)
                && (!m0[mtcp_pkg::GATE_POS] || g0)) begin
                if (bump(m0[1:0], tl0, th0)) tf[0] = 1'b1;
            end
            if (tr[1] && m0[1:0] == mtcp_pkg::MODE_SPLIT) begin
                if (tick) begin
                    if (th0 == mtcp_pkg::BYTE_MAX) tf[1] = 1'b1;
                    th0 = th0 + 8'd1;
                end
            end else if (tr[1] && m1[1:0] != mtcp_pkg::MODE_SPLIT
                         && (m1[mtcp_pkg::CT_POS] ? src == mtcp_pkg::OP_T1_PULSE : tick)
                         && (!m1[mtcp_pkg::GATE_POS] || g1)) begin
                if (bump(m1[1:0], tl1, th1)) tf[1] = 1'b1;
            end
        endfunction

        function void note_accepted(input mtcp_pkg::in_t t);
            mtcp_pkg::out_t r;
            logic [2:0]     req, hp;
            int             e;
            req = '0;
            hp = '0;
            if (t.tf2_set) tf[2] = 1'b1;
            case (t.op)
                mtcp_pkg::OP_TICK: begin
                    if (!ext_mode) count(mtcp_pkg::OP_TICK, t.gate0_level, t.gate1_level);
                    if (ie[mtcp_pkg::IE_EA_POS]) begin
                        for (int i = 0; i < 3; i++) begin
                            e = 2 * i + 1;
                            if (tf[i] && ie[e]) begin
                                if (ip[e]) begin
                                    if (t.nest_level < 2'd2) begin
                                        req[i] = 1'b1;
                                        hp[i] = 1'b1;
                                    end
                                end else if (t.nest_level == 2'd0) begin
                                    req[i] = 1'b1;
                                end
                            end
                        end
                    end
                end
                mtcp_pkg::OP_EXT_CLK: begin
                    ext_mode = t.ext_clk_enable;
                    if (t.ext_clk_enable) begin
                        count(mtcp_pkg::OP_TICK, t.gate0_level, t.gate1_level);
                    end
                end
                mtcp_pkg::OP_T0_PULSE, mtcp_pkg::OP_T1_PULSE, mtcp_pkg::OP_T2_PULSE: begin
                    count(t.op, t.gate0_level, t.gate1_level);
                end
                mtcp_pkg::OP_ENTRY: begin
                    if (t.entered_vector != mtcp_pkg::VEC_OTHER) pend[t.entered_vector] = 1'b1;
                end
                mtcp_pkg::OP_EXIT: begin
                    tf = tf & ~pend;
                    pend = '0;
                end
                mtcp_pkg::OP_WRITE: begin
                    case (t.reg_select)
                        mtcp_pkg::SEL_TL0: tl0 = t.write_data;
                        mtcp_pkg::SEL_TH0: th0 = t.write_data;
                        mtcp_pkg::SEL_TL1: tl1 = t.write_data;
                        mtcp_pkg::SEL_TH1: th1 = t.write_data;
                    endcase
                end
            endcase
            r.low0 = tl0;
            r.high0 = th0;
            r.low1 = tl1;
            r.high1 = th1;
            r.overflow_flags = tf;
            r.irq_request = req;
            r.irq_high = hp;
            awaited.push_back(r);
        endfunction

        function void diff(input string name, input logic [7:0] want, input logic [7:0] got);
            if (want !== got) begin
                failures++;
                if (failures <= 10) begin
                    $display("Mismatch on %s: expected %0h, got %0h", name, want, got);
                end
            end
        endfunction

        function void check_result(input mtcp_pkg::out_t got);
            mtcp_pkg::out_t want;
            if (awaited.size() == 0) begin
                failures++;
                if (failures <= 10) $display("Result with no transaction pending: %p", got);
                return;
            end
            want = awaited.pop_front();
            diff("low0", want.low0, got.low0);
            diff("high0", want.high0, got.high0);
            diff("low1", want.low1, got.low1);
            diff("high1", want.high1, got.high1);
            diff("overflow_flags", 8'(want.overflow_flags), 8'(got.overflow_flags));
            diff("irq_request", 8'(want.irq_request), 8'(got.irq_request));
            diff("irq_high", 8'(want.irq_high), 8'(got.irq_high));
        endfunction
    endclass

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    mtcp_pkg::in_t                    s_data;
    logic                             m_valid;
    logic                             m_ready;
    mtcp_pkg::out_t                   m_data;
    logic                             cfg_wen;
    logic [mtcp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mtcp_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    logic send_eager = 1'b0;
    logic recv_eager = 1'b0;
    int   cycles = 0;

    timer_pair_scoreboard sb = new();

    mcu_timer_counter_pair_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_accepted(s_data);
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    function automatic mtcp_pkg::in_t mk(input logic [2:0] op, input logic [7:0] arg = 8'd0,
                                         input logic [1:0] sel = 2'd0);
        mtcp_pkg::in_t t;
        t.op = op;
        t.ext_clk_enable = arg[0];
        t.gate0_level = 1'b1;
        t.gate1_level = 1'b1;
        t.nest_level = sel;
        t.entered_vector = sel;
        t.tf2_set = 1'b0;
        t.reg_select = sel;
        t.write_data = arg;
        return t;
    endfunction

    function automatic mtcp_pkg::in_t rand_item();
        mtcp_pkg::in_t t;
        int            pick;
        pick = $urandom_range(0, 99);
        t.op = pick < 30 ? mtcp_pkg::OP_TICK :
               pick < 38 ? mtcp_pkg::OP_EXT_CLK :
               pick < 52 ? mtcp_pkg::OP_T0_PULSE :
               pick < 64 ? mtcp_pkg::OP_T1_PULSE :
               pick < 69 ? mtcp_pkg::OP_T2_PULSE :
               pick < 77 ? mtcp_pkg::OP_ENTRY :
               pick < 84 ? mtcp_pkg::OP_EXIT : mtcp_pkg::OP_WRITE;
        t.ext_clk_enable = 1'($urandom_range(0, 1));
        t.gate0_level = ($urandom_range(0, 3) != 0);
        t.gate1_level = ($urandom_range(0, 3) != 0);
        t.nest_level = 2'($urandom_range(0, 3));
        t.entered_vector = 2'($urandom_range(0, 3));
        t.tf2_set = ($urandom_range(0, 9) == 0);
        t.reg_select = 2'($urandom_range(0, 3));
        t.write_data = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: t.write_data = mtcp_pkg::BYTE_MAX;
            1: t.write_data[4:0] = mtcp_pkg::LOW5_MAX;
            default: ;
        endcase
        return t;
    endfunction

    task automatic send_item(input mtcp_pkg::in_t t);
        int gap;
        gap = send_eager ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= t;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        sb.write_reg(idx, d);
        @(negedge aclk);
    endtask

    task automatic set_config(input logic [7:0] tmod, input logic [1:0] tr,
                              input logic [7:0] ie, input logic [7:0] ip);
        wait_idle();
        write_reg(mtcp_pkg::REG_MODE, tmod);
        write_reg(mtcp_pkg::REG_RUN, {6'd0, tr});
        write_reg(mtcp_pkg::REG_INT_EN, ie);
        write_reg(mtcp_pkg::REG_INT_PRIO, ip);
        cfg_wen <= 1'b0;
    endtask

    initial begin
        int gap;
        int results;
        m_ready = 1'b0;
        results = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = recv_eager ? 0 : $urandom_range(0, 7);
            if (results == HOLD_AFTER) gap = LONG_HOLD;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
            results++;
        end
    end

    initial begin
        mtcp_pkg::in_t t;
        s_valid = 1'b0;
        s_data = '0;
        cfg_wen = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Timer 0 in 16-bit mode, timer 1 in 13-bit mode, timer 1 high priority.
        set_config(8'h01, 2'b11, 8'hAA, 8'h08);
        send_item(mk(mtcp_pkg::OP_WRITE, 8'hFF, mtcp_pkg::SEL_TL0));
        send_item(mk(mtcp_pkg::OP_WRITE, 8'hFF, mtcp_pkg::SEL_TH0));
        send_item(mk(mtcp_pkg::OP_WRITE, 8'hFF, mtcp_pkg::SEL_TL1));
        send_item(mk(mtcp_pkg::OP_WRITE, 8'hFF, mtcp_pkg::SEL_TH1));
        send_item(mk(mtcp_pkg::OP_TICK, 8'd0, 2'd0));
        send_item(mk(mtcp_pkg::OP_TICK, 8'd0, 2'd1));
        send_item(mk(mtcp_pkg::OP_TICK, 8'd0, 2'd2));
        send_item(mk(mtcp_pkg::OP_TICK, 8'd0, 2'd3));
        t = mk(mtcp_pkg::OP_TICK);
        t.tf2_set = 1'b1;
        send_item(t);
        send_item(mk(mtcp_pkg::OP_ENTRY, 8'd0, 2'd0));
        send_item(mk(mtcp_pkg::OP_ENTRY, 8'd0, mtcp_pkg::VEC_OTHER));
        t = mk(mtcp_pkg::OP_EXIT);
        t.tf2_set = 1'b1;
        send_item(t);
        send_item(mk(mtcp_pkg::OP_ENTRY, 8'd0, 2'd1));
        send_item(mk(mtcp_pkg::OP_ENTRY, 8'd0, 2'd2));
        send_item(mk(mtcp_pkg::OP_EXIT));
        send_item(mk(mtcp_pkg::OP_EXT_CLK, 8'd1));
        send_item(mk(mtcp_pkg::OP_TICK));
        send_item(mk(mtcp_pkg::OP_EXT_CLK, 8'd0));
        send_item(mk(mtcp_pkg::OP_T0_PULSE));
        send_item(mk(mtcp_pkg::OP_T1_PULSE));
        send_item(mk(mtcp_pkg::OP_T2_PULSE));

        // Split mode on timer 0, timer 1 held in mode 3.
        set_config(8'h33, 2'b11, 8'hAA, 8'h2A);
        send_item(mk(mtcp_pkg::OP_WRITE, 8'hFF, mtcp_pkg::SEL_TL0));
        send_item(mk(mtcp_pkg::OP_WRITE, 8'hFF, mtcp_pkg::SEL_TH0));
        send_item(mk(mtcp_pkg::OP_TICK));

        // Gated pin counters with auto-reload.
        set_config(8'hEE, 2'b11, 8'h80, 8'h00);
        send_item(mk(mtcp_pkg::OP_WRITE, 8'h80, mtcp_pkg::SEL_TH0));
        send_item(mk(mtcp_pkg::OP_WRITE, 8'hFF, mtcp_pkg::SEL_TL0));
        t = mk(mtcp_pkg::OP_T0_PULSE);
        t.gate0_level = 1'b0;
        send_item(t);
        send_item(mk(mtcp_pkg::OP_T0_PULSE));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_config(8'hFF, 2'b11, 8'hFF, 8'hFF);
                1: set_config(8'h00, 2'b00, 8'h00, 8'h00);
                default: begin
                    set_config(8'($urandom_range(0, 255)),
                               ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 3)) : 2'b11,
                               {($urandom_range(0, 3) != 0), 7'($urandom_range(0, 127))},
                               8'($urandom_range(0, 255)));
                end
            endcase
            send_eager = (p % 2 == 1);
            recv_eager = (p % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) send_item(rand_item());
        end

        wait_idle();
        if (sb.failures == 0 && sb.awaited.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ mcu_timer_counter_pair_top.f @@
+incdir+design
design/mtcp_pkg.sv
design/mtcp_update.sv
design/mcu_timer_counter_pair_top.sv
design/mtcp_checker.sv
sim/tb_mcu_timer_counter_pair_top.sv
